/* hw/rtl/aidr_pkg.sv */
// Shared types, constants and start-code helper functions for the Annex B IDR frame splitter.
// Used by aidr_decide, aidr_result_reg and the top level. No dependencies.
package aidr_pkg;

  localparam int unsigned FRAME_INDEX_BITS_DEF = 32;
  localparam int unsigned HOLD_DEPTH           = 5;
  localparam int unsigned WIN_DEPTH            = 6;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
  localparam logic [7:0] SC_ZERO       = 8'h00;
  localparam logic [7:0] SC_ONE        = 8'h01;
  localparam logic [2:0] SC_LONG       = 3'd4;
  localparam logic [2:0] SC_SHORT      = 3'd3;

  // Byte k of the decision window sits in entry k.
  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  // Scan state carried from one decision to the next.
  typedef struct packed {
    logic [2:0] skip;
    logic       in_frame;
    logic       next_first;
  } aidr_ctl_t;

  // Per-byte outcome handed to the result register.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run_last;
  } aidr_res_t;

  // Size of a start code at position p (0 or 1) of a window holding rl valid bytes.
  function automatic logic [2:0] code_size(win_t w, logic [2:0] rl, logic [2:0] p);
    logic [3:0] end4;
    logic [3:0] end3;
    logic [2:0] size;
    end4 = 4'(p) + 4'(SC_LONG);
    end3 = 4'(p) + 4'(SC_SHORT);
    size = 3'd0;
    if (end4 <= 4'(rl) && w[p] == SC_ZERO && w[3'(p + 3'd1)] == SC_ZERO &&
        w[3'(p + 3'd2)] == SC_ZERO && w[3'(p + 3'd3)] == SC_ONE) begin
      size = SC_LONG;
    end else if (end3 <= 4'(rl) && w[p] == SC_ZERO && w[3'(p + 3'd1)] == SC_ZERO &&
                 w[3'(p + 3'd2)] == SC_ONE) begin
      size = SC_SHORT;
    end
    return size;
  endfunction

  // True when a start code at position p is followed by an IDR NAL header inside the window.
  function automatic logic idr_at(win_t w, logic [2:0] rl, logic [2:0] p);
    logic [2:0] size;
    logic [3:0] pos;
    logic       hit;
    size = code_size(w, rl, p);
    pos  = 4'(p) + 4'(size);
    hit  = 1'b0;
    if (size != 3'd0 && pos < 4'(rl)) begin
      hit = (w[pos[2:0]][4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR;
    end
    return hit;
  endfunction

endpackage

/* hw/rtl/aidr_decide.sv */
// Decision logic for one byte at the head of the window: start-code skip, IDR detection,
// frame counting and the first/last marks. Depends on aidr_pkg.
module aidr_decide #(
  parameter int unsigned FRAME_INDEX_BITS = aidr_pkg::FRAME_INDEX_BITS_DEF
) (
  input  aidr_pkg::win_t                win_i,
  input  logic [2:0]                    len_i,
  input  logic                          eos_i,
  input  aidr_pkg::aidr_ctl_t           ctl_i,
  input  logic [FRAME_INDEX_BITS-1:0]   cnt_i,
  output aidr_pkg::aidr_ctl_t           ctl_o,
  output logic [FRAME_INDEX_BITS-1:0]   cnt_o,
  output logic                          emit_o,
  output logic                          first_o,
  output logic                          last_o
);
  import aidr_pkg::*;

  logic [2:0] size;
  logic       opens;
  logic       in_frame_n;
  logic       first_n;

  always_comb begin
    size  = code_size(win_i, len_i, 3'd0);
    opens = 1'b0;
    ctl_o = ctl_i;
    cnt_o = cnt_i;
    if (ctl_i.skip != 3'd0) begin
      ctl_o.skip = ctl_i.skip - 3'd1;
    end else if (size != 3'd0) begin
      ctl_o.skip = size - 3'd1;
      opens      = idr_at(win_i, len_i, 3'd0);
    end
    in_frame_n = ctl_i.in_frame;
    first_n    = ctl_i.next_first;
    if (opens) begin
      // The index stops at its largest value rather than wrapping.
      if (ctl_i.in_frame && cnt_i != '1) begin
        cnt_o = cnt_i + 1'b1;
      end
      in_frame_n = 1'b1;
      first_n    = 1'b1;
    end
    emit_o   = in_frame_n;
    first_o  = first_n;
    last_o   = (eos_i && len_i == 3'd1) ||
               (ctl_o.skip == 3'd0 && len_i > 3'd1 && idr_at(win_i, len_i, 3'd1));
    ctl_o.in_frame   = in_frame_n;
    ctl_o.next_first = in_frame_n ? 1'b0 : first_n;
  end

endmodule

/* hw/rtl/aidr_result_reg.sv */
// Output register of the splitter: holds one result item, adds the timestamp base and
// packs the stream fields. Depends on aidr_pkg.
module aidr_result_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  aidr_pkg::aidr_res_t  res_i,
  input  logic [63:0]          index_i,
  input  logic [63:0]          base_i,
  output logic                 free_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] frame_byte, [39:8] frame_index, [103:40] frame_time
  output logic [103:0]         m_axis_tdata_o,
  // [0] frame_first, [1] run_last
  output logic [1:0]           m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);
  import aidr_pkg::*;

  logic        valid_q, valid_d;
  aidr_res_t   res_q;
  logic [31:0] index_q;
  logic [63:0] time_q;

  assign free_o  = !valid_q || m_axis_tready_i;
  assign valid_d = load_i ? 1'b1 : (m_axis_tready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q   <= res_i;
      index_q <= index_i[31:0];
      time_q  <= base_i + index_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {time_q, index_q, res_q.data};
  assign m_axis_tuser_o  = {res_q.run_last, res_q.first};
  assign m_axis_tlast_o  = res_q.last;

endmodule

/* hw/rtl/annexb_idr_frame_splitter_unit.sv */
// Annex B IDR frame splitter, top level: five-byte hold line, end-of-stream flush sequencer.
// A byte is decided when the fifth byte after it is accepted and is registered at the output in the next cycle.
// Throughput: one byte per cycle while the output accepts; an end-of-stream item holds the input
// while the shared decision unit walks the held bytes, one per cycle while the output accepts.
// Reset: asynchronous, active low; clears the scan state and the timestamp base.
// Depends on aidr_pkg, aidr_decide and aidr_result_reg.
module annexb_idr_frame_splitter_unit #(
  parameter int unsigned FRAME_INDEX_BITS = aidr_pkg::FRAME_INDEX_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i,      // timestamp_base
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,   // [7:0] data_byte
  input  logic          s_axis_tlast_i,   // end_of_stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [103:0]  m_axis_tdata_o,   // [7:0] frame_byte, [39:8] frame_index,
                                          // [103:40] frame_time
  output logic [1:0]    m_axis_tuser_o,   // [0] frame_first, [1] run_last
  output logic          m_axis_tlast_o    // frame_last
);
  import aidr_pkg::*;

  // Hold line: bytes that still wait for five successors. During a flush the
  // final byte sits either in the hold line or, with a full line, in tail_q.
  logic [HOLD_DEPTH-1:0][7:0] hold_q, hold_d;
  logic [7:0]                 tail_q, tail_d;
  logic [2:0]                 pending_q, pending_d;
  logic                       flush_q, flush_d;
  logic [2:0]                 fidx_q, fidx_d;
  aidr_ctl_t                  ctl_q, ctl_d;
  logic [FRAME_INDEX_BITS-1:0] cnt_q, cnt_d;
  logic [63:0]                base_q;

  logic       out_free;
  logic       accept;
  logic       normal_go;
  logic       flush_go;
  logic       flush_end;
  win_t       win_full;
  win_t       win_dec;
  logic [2:0] len_dec;
  logic [3:0] shift_pos [WIN_DEPTH];

  aidr_ctl_t                   dec_ctl;
  logic [FRAME_INDEX_BITS-1:0] dec_cnt;
  logic                        dec_emit;
  logic                        dec_first;
  logic                        dec_last;
  aidr_res_t                   res;

  assign s_axis_tready_o = !flush_q && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  // A plain byte on a full hold line decides the oldest byte at once.
  assign normal_go       = accept && !s_axis_tlast_i && pending_q == 3'(HOLD_DEPTH);
  assign flush_go        = flush_q && out_free;
  assign flush_end       = flush_go && fidx_q == pending_q;

  // Window seen by the decision unit. In normal running it is the hold line plus
  // the incoming byte; during a flush it is the stored window shifted so that the
  // byte under decision sits at position zero.
  always_comb begin
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      win_full[k] = hold_q[k];
    end
    win_full[WIN_DEPTH-1] = flush_q ? tail_q : s_axis_tdata_i;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      shift_pos[k] = 4'(k) + 4'(fidx_q);
      if (!flush_q) begin
        win_dec[k] = win_full[k];
      end else if (shift_pos[k] < 4'(WIN_DEPTH)) begin
        win_dec[k] = win_full[shift_pos[k][2:0]];
      end else begin
        win_dec[k] = SC_ZERO;
      end
    end
    len_dec = flush_q ? 3'(pending_q - fidx_q + 3'd1) : 3'(WIN_DEPTH);
  end

  aidr_decide #(
    .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
  ) u_decide (
    .win_i   (win_dec),
    .len_i   (len_dec),
    .eos_i   (flush_q),
    .ctl_i   (ctl_q),
    .cnt_i   (cnt_q),
    .ctl_o   (dec_ctl),
    .cnt_o   (dec_cnt),
    .emit_o  (dec_emit),
    .first_o (dec_first),
    .last_o  (dec_last)
  );

  assign res.data     = win_dec[0];
  assign res.first    = dec_first;
  assign res.last     = dec_last;
  // A normal step gives at most one item; in a flush every byte after the first
  // frame byte is sent, so the final window byte ends the run.
  assign res.run_last = flush_q ? (fidx_q == pending_q) : 1'b1;

  aidr_result_reg u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          ((normal_go || flush_go) && dec_emit),
    .res_i           (res),
    .index_i         (64'(dec_cnt)),
    .base_i          (base_q),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Next-state logic for the hold line, the flush sequencer and the scan state.
  always_comb begin
    hold_d    = hold_q;
    tail_d    = tail_q;
    pending_d = pending_q;
    flush_d   = flush_q;
    fidx_d    = fidx_q;
    ctl_d     = ctl_q;
    cnt_d     = cnt_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        // Park the final byte behind the held ones and start the flush walk.
        if (pending_q == 3'(HOLD_DEPTH)) begin
          tail_d = s_axis_tdata_i;
        end else begin
          for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (3'(k) == pending_q) begin
              hold_d[k] = s_axis_tdata_i;
            end
          end
        end
        flush_d = 1'b1;
        fidx_d  = 3'd0;
      end else if (pending_q == 3'(HOLD_DEPTH)) begin
        for (int k = 0; k < HOLD_DEPTH - 1; k++) begin
          hold_d[k] = hold_q[k+1];
        end
        hold_d[HOLD_DEPTH-1] = s_axis_tdata_i;
      end else begin
        for (int k = 0; k < HOLD_DEPTH; k++) begin
          if (3'(k) == pending_q) begin
            hold_d[k] = s_axis_tdata_i;
          end
        end
        pending_d = pending_q + 3'd1;
      end
    end
    if (normal_go || flush_go) begin
      ctl_d = dec_ctl;
      cnt_d = dec_cnt;
    end
    if (flush_go) begin
      fidx_d = fidx_q + 3'd1;
    end
    if (flush_end) begin
      // The stream is over: the hold count, flush sequencer, scan state and frame index return to reset.
      flush_d   = 1'b0;
      fidx_d    = 3'd0;
      pending_d = 3'd0;
      ctl_d     = '0;
      cnt_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
      flush_q   <= 1'b0;
      fidx_q    <= 3'd0;
      ctl_q     <= '0;
      cnt_q     <= '0;
      base_q    <= 64'd0;
      hold_q    <= '0;
    end else begin
      pending_q <= pending_d;
      flush_q   <= flush_d;
      fidx_q    <= fidx_d;
      ctl_q     <= ctl_d;
      cnt_q     <= cnt_d;
      hold_q    <= hold_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
  end

  // The input must stay closed while held bytes are being flushed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !s_axis_tready_o)
    else $error("input open during flush");

  // The flush walk never runs past the stored window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> fidx_q <= pending_q)
    else $error("flush index beyond window");

  // The hold line never claims more bytes than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'(HOLD_DEPTH))
    else $error("hold count overflow");

  // The last flush step leaves the scan state at its reset value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_end |=> !flush_q && pending_q == 3'd0 && ctl_q == '0 && cnt_q == '0)
    else $error("state not cleared after flush");

endmodule
